>>> rtl/first_fit_heap_allocator_defines.svh
// assertion macros for the first fit heap allocator checker
// depends on clk_i and rst_ni being visible where a macro is used
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// condition implies a consequence in the same cycle
`define FFHA_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// condition implies a consequence in the next cycle
`define FFHA_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ffha_pkg.sv
// shared types and constants for the first fit heap allocator
// no dependencies
`default_nettype none

package ffha_pkg;

  localparam int TableDepth  = 64;
  localparam int IdxW        = $clog2(TableDepth);
  localparam int CntW        = IdxW + 1;
  localparam int HeaderBytes = 16;
  localparam int Grain       = 16;
  localparam int GrainMask   = 15;

  // request codes
  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_ADD   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_ALIGN = 3'd2;
  localparam logic [2:0] ST_BAD   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] req_size;
    logic [31:0] req_align;
    logic [31:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] data_addr;
    logic [2:0]  status;
  } res_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] payload;
    logic        free;
  } entry_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_EVAL,
    OP_SETST,
    OP_ALLOC_HIT,
    OP_PAD,
    OP_ADD_SET,
    OP_NEXT_INS,
    OP_IRD,
    OP_IMOVE,
    OP_IWRITE,
    OP_FMARK,
    OP_FNEXT,
    OP_FPREV,
    OP_DRD,
    OP_DMOVE,
    OP_DEND,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] st;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       aln;
    logic       pre_err;
    logic       scan_end;
    logic       match;
    logic       best_vld;
    logic       full;
    logic       pend1;
    logic       pend2;
    logic       idx_eq_ins;
    logic       del_last;
    logic       cur_free;
    logic       has_next;
    logic       next_merge;
    logic       prev_merge;
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/ffha_datapath.sv
// block table memory, scan compare logic and working registers
// depends on ffha_pkg
`default_nettype none

module ffha_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ffha_pkg::cmd_t      cmd_i,
  input  wire ffha_pkg::req_t      req_i,
  output ffha_pkg::dp_status_t     status_o,
  output logic                     done_o,
  output ffha_pkg::res_t           res_o
);

  localparam int IdxW = ffha_pkg::IdxW;
  localparam int CntW = ffha_pkg::CntW;

  ffha_pkg::entry_t mem [ffha_pkg::TableDepth];

  // latched request
  logic [1:0]  func_q;
  logic        aln_q;
  logic [32:0] size_q;
  logic [31:0] align_q, am_q, addr_q, len_q, last_q;
  logic [2:0]  st_q;
  logic [31:0] res_addr_q;

  // indexes and counters
  logic [CntW-1:0] idx_q, ins_q, ipos_q, cnt_q;
  logic [IdxW-1:0] hit_q;
  logic            insf_q;

  // entries in flight
  ffha_pkg::entry_t rd_q, cur_q, prev_q, new_q, new2_q;

  // best fit for padded aligned allocation
  logic            best_vld_q;
  logic [IdxW-1:0] best_idx_q;
  logic [31:0]     best_p_q, best_pad_q, best_start_q;

  logic pend1_q, pend2_q;
  logic done_q;
  ffha_pkg::res_t res_q;

  // scan compare
  logic [31:0] d_c, pad0_c, pad_c;
  logic [34:0] need_c;
  logic [33:0] bl_c;
  logic        dfit_c, afit_c, pfit_c, better_c, fmatch_c, ovl_c, match_c;

  assign d_c    = rd_q.start + 32'(ffha_pkg::HeaderBytes);
  assign pad0_c = (32'd0 - d_c) & am_q;
  assign pad_c  = (pad0_c < 32'(ffha_pkg::Grain)) ? pad0_c + align_q : pad0_c;
  assign need_c = 35'(pad_c) + 35'(ffha_pkg::HeaderBytes) + 35'(size_q);
  assign pfit_c = rd_q.free && (35'(rd_q.payload) >= need_c);
  assign better_c = !best_vld_q || (rd_q.payload < best_p_q);
  assign dfit_c = rd_q.free && (33'(rd_q.payload) >= size_q);
  assign afit_c = dfit_c && ((d_c & am_q) == 32'd0);
  assign fmatch_c = (d_c == addr_q);
  assign bl_c   = 34'(rd_q.start) + 34'(rd_q.payload) + 34'(ffha_pkg::HeaderBytes - 1);
  assign ovl_c  = (34'(addr_q) <= bl_c) && (rd_q.start <= last_q);

  always_comb begin
    case (func_q)
      ffha_pkg::FUNC_ALLOC: match_c = aln_q ? afit_c : dfit_c;
      ffha_pkg::FUNC_FREE:  match_c = fmatch_c;
      ffha_pkg::FUNC_ADD:   match_c = ovl_c;
      default:              match_c = 1'b0;
    endcase
  end

  // split of a first fit hit
  logic [31:0] rest_c;
  logic        split_c;
  assign rest_c  = rd_q.payload - size_q[31:0];
  assign split_c = (cnt_q < CntW'(ffha_pkg::TableDepth)) &&
                   (rest_c >= 32'(ffha_pkg::HeaderBytes + ffha_pkg::Grain));

  // front pad carve of the best block
  logic [31:0] ns_c, np_c, rest2_c;
  logic        split2_c;
  assign ns_c     = best_start_q + 32'(ffha_pkg::HeaderBytes) + best_pad_q;
  assign np_c     = best_p_q - best_pad_q - 32'(ffha_pkg::HeaderBytes);
  assign rest2_c  = np_c - size_q[31:0];
  assign split2_c = (cnt_q < CntW'(ffha_pkg::TableDepth - 1)) &&
                    (rest2_c >= 32'(ffha_pkg::HeaderBytes + ffha_pkg::Grain));

  // neighbor merge checks on free
  logic [31:0] cend_c, pend_c, nmerged_c, pmerged_c;
  assign cend_c    = cur_q.start + 32'(ffha_pkg::HeaderBytes) + cur_q.payload;
  assign pend_c    = prev_q.start + 32'(ffha_pkg::HeaderBytes) + prev_q.payload;
  assign nmerged_c = cur_q.payload + 32'(ffha_pkg::HeaderBytes) + rd_q.payload;
  assign pmerged_c = prev_q.payload + 32'(ffha_pkg::HeaderBytes) + cur_q.payload;

  // pre checks on the incoming request
  logic [2:0]  pre_st_c;
  logic [32:0] add_end_c;
  logic [31:0] align_m1_c;
  assign add_end_c  = 33'(req_i.req_addr) + 33'(req_i.req_size);
  assign align_m1_c = req_i.req_align - 32'd1;

  always_comb begin
    pre_st_c = ffha_pkg::ST_OK;
    case (req_i.func)
      ffha_pkg::FUNC_ALLOC: begin
        if (req_i.req_align != 32'd0 && (req_i.req_align & align_m1_c) != 32'd0)
          pre_st_c = ffha_pkg::ST_ALIGN;
      end
      ffha_pkg::FUNC_FREE: pre_st_c = ffha_pkg::ST_OK;
      ffha_pkg::FUNC_ADD: begin
        if (((req_i.req_addr | req_i.req_size) & 32'(ffha_pkg::GrainMask)) != 32'd0)
          pre_st_c = ffha_pkg::ST_ALIGN;
        else if (req_i.req_size < 32'(ffha_pkg::HeaderBytes + ffha_pkg::Grain) ||
                 add_end_c > 33'h1_0000_0000)
          pre_st_c = ffha_pkg::ST_BAD;
      end
      default: pre_st_c = ffha_pkg::ST_BAD;
    endcase
  end

  // memory ports
  logic [CntW-1:0]  raddr_c, waddr_c;
  logic             re_c, we_c;
  ffha_pkg::entry_t wdata_c;

  always_comb begin
    re_c    = 1'b0;
    raddr_c = idx_q;
    we_c    = 1'b0;
    waddr_c = idx_q;
    wdata_c = rd_q;
    case (cmd_i.op)
      ffha_pkg::OP_READ: re_c = 1'b1;
      ffha_pkg::OP_IRD: begin
        re_c    = 1'b1;
        raddr_c = idx_q - CntW'(1);
      end
      ffha_pkg::OP_DRD: begin
        re_c    = 1'b1;
        raddr_c = idx_q + CntW'(1);
      end
      ffha_pkg::OP_ALLOC_HIT: begin
        we_c    = 1'b1;
        wdata_c = '{start: rd_q.start,
                    payload: split_c ? size_q[31:0] : rd_q.payload,
                    free: 1'b0};
      end
      ffha_pkg::OP_PAD: begin
        we_c    = 1'b1;
        waddr_c = CntW'(best_idx_q);
        wdata_c = '{start: best_start_q, payload: best_pad_q, free: 1'b1};
      end
      ffha_pkg::OP_IWRITE: begin
        we_c    = 1'b1;
        waddr_c = ins_q;
        wdata_c = new_q;
      end
      ffha_pkg::OP_IMOVE, ffha_pkg::OP_DMOVE: we_c = 1'b1;
      ffha_pkg::OP_FMARK: begin
        we_c    = 1'b1;
        waddr_c = CntW'(hit_q);
        wdata_c = '{start: cur_q.start, payload: cur_q.payload, free: 1'b1};
      end
      ffha_pkg::OP_FNEXT: begin
        we_c    = 1'b1;
        waddr_c = CntW'(hit_q);
        wdata_c = '{start: cur_q.start, payload: nmerged_c, free: 1'b1};
      end
      ffha_pkg::OP_FPREV: begin
        we_c    = 1'b1;
        waddr_c = CntW'(hit_q) - CntW'(1);
        wdata_c = '{start: prev_q.start, payload: pmerged_c, free: 1'b1};
      end
      default: ;
    endcase
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (we_c) mem[waddr_c[IdxW-1:0]] <= wdata_c;
    if (re_c) rd_q <= mem[raddr_c[IdxW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      pend1_q    <= 1'b0;
      pend2_q    <= 1'b0;
      done_q     <= 1'b0;
      best_vld_q <= 1'b0;
      insf_q     <= 1'b0;
    end else begin
      done_q <= (cmd_i.op == ffha_pkg::OP_OUT);
      case (cmd_i.op)
        ffha_pkg::OP_LOAD: begin
          pend1_q    <= 1'b0;
          pend2_q    <= 1'b0;
          best_vld_q <= 1'b0;
          insf_q     <= 1'b0;
        end
        ffha_pkg::OP_EVAL: begin
          if (!match_c) begin
            if (func_q == ffha_pkg::FUNC_ALLOC && aln_q && pfit_c && better_c)
              best_vld_q <= 1'b1;
            if (rd_q.start > addr_q) insf_q <= 1'b1;
          end
        end
        ffha_pkg::OP_ALLOC_HIT: pend1_q <= split_c;
        ffha_pkg::OP_PAD: begin
          pend1_q <= 1'b1;
          pend2_q <= split2_c;
        end
        ffha_pkg::OP_ADD_SET: pend1_q <= 1'b1;
        ffha_pkg::OP_NEXT_INS: begin
          pend1_q <= pend2_q;
          pend2_q <= 1'b0;
        end
        ffha_pkg::OP_IWRITE: begin
          pend1_q <= 1'b0;
          cnt_q   <= cnt_q + CntW'(1);
        end
        ffha_pkg::OP_DEND: cnt_q <= cnt_q - CntW'(1);
        default: ;
      endcase
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ffha_pkg::OP_OUT)
      res_q <= '{data_addr: (st_q == ffha_pkg::ST_OK) ? res_addr_q : 32'd0, status: st_q};
    case (cmd_i.op)
      ffha_pkg::OP_LOAD: begin
        func_q     <= req_i.func;
        aln_q      <= req_i.req_align > 32'(ffha_pkg::Grain);
        size_q     <= (33'(req_i.req_size) + 33'(ffha_pkg::GrainMask)) &
                      ~33'(ffha_pkg::GrainMask);
        align_q    <= req_i.req_align;
        am_q       <= align_m1_c;
        addr_q     <= req_i.req_addr;
        len_q      <= req_i.req_size;
        last_q     <= req_i.req_addr + req_i.req_size - 32'd1;
        st_q       <= pre_st_c;
        res_addr_q <= 32'd0;
        idx_q      <= '0;
        ipos_q     <= '0;
      end
      ffha_pkg::OP_SETST: st_q <= cmd_i.st;
      ffha_pkg::OP_EVAL: begin
        if (match_c) begin
          cur_q <= rd_q;
          hit_q <= idx_q[IdxW-1:0];
        end else begin
          idx_q  <= idx_q + CntW'(1);
          prev_q <= rd_q;
          if (func_q == ffha_pkg::FUNC_ALLOC && aln_q && pfit_c && better_c) begin
            best_idx_q   <= idx_q[IdxW-1:0];
            best_p_q     <= rd_q.payload;
            best_pad_q   <= pad_c;
            best_start_q <= rd_q.start;
          end
          if (!insf_q && rd_q.start <= addr_q) ipos_q <= idx_q + CntW'(1);
        end
      end
      ffha_pkg::OP_ALLOC_HIT: begin
        new_q      <= '{start: rd_q.start + 32'(ffha_pkg::HeaderBytes) + size_q[31:0],
                        payload: rest_c - 32'(ffha_pkg::HeaderBytes),
                        free: 1'b1};
        ins_q      <= idx_q + CntW'(1);
        idx_q      <= cnt_q;
        res_addr_q <= d_c;
      end
      ffha_pkg::OP_PAD: begin
        new_q      <= '{start: ns_c,
                        payload: split2_c ? size_q[31:0] : np_c,
                        free: 1'b0};
        new2_q     <= '{start: ns_c + 32'(ffha_pkg::HeaderBytes) + size_q[31:0],
                        payload: rest2_c - 32'(ffha_pkg::HeaderBytes),
                        free: 1'b1};
        ins_q      <= CntW'(best_idx_q) + CntW'(1);
        idx_q      <= cnt_q;
        res_addr_q <= ns_c + 32'(ffha_pkg::HeaderBytes);
      end
      ffha_pkg::OP_ADD_SET: begin
        new_q <= '{start: addr_q, payload: len_q - 32'(ffha_pkg::HeaderBytes),
                   free: 1'b1};
        ins_q <= ipos_q;
        idx_q <= cnt_q;
      end
      ffha_pkg::OP_NEXT_INS: begin
        new_q <= new2_q;
        ins_q <= ins_q + CntW'(1);
        idx_q <= cnt_q;
      end
      ffha_pkg::OP_IMOVE: idx_q <= idx_q - CntW'(1);
      ffha_pkg::OP_FMARK: begin
        st_q       <= ffha_pkg::ST_OK;
        cur_q.free <= 1'b1;
        idx_q      <= CntW'(hit_q) + CntW'(1);
      end
      ffha_pkg::OP_FNEXT: cur_q.payload <= nmerged_c;
      ffha_pkg::OP_FPREV: idx_q <= CntW'(hit_q);
      ffha_pkg::OP_DMOVE: idx_q <= idx_q + CntW'(1);
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    status_o.func       = func_q;
    status_o.aln        = aln_q;
    status_o.pre_err    = (st_q != ffha_pkg::ST_OK);
    status_o.scan_end   = (idx_q == cnt_q);
    status_o.match      = match_c;
    status_o.best_vld   = best_vld_q;
    status_o.full       = (cnt_q == CntW'(ffha_pkg::TableDepth));
    status_o.pend1      = pend1_q;
    status_o.pend2      = pend2_q;
    status_o.idx_eq_ins = (idx_q == ins_q);
    status_o.del_last   = (idx_q + CntW'(1) == cnt_q);
    status_o.cur_free   = cur_q.free;
    status_o.has_next   = (CntW'(hit_q) + CntW'(1) < cnt_q);
    status_o.next_merge = rd_q.free && (cend_c == rd_q.start);
    status_o.prev_merge = (hit_q != '0) && prev_q.free && (pend_c == cur_q.start);
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> rtl/ffha_ctrl.sv
// sequencer for scan, insert shift, delete shift and merge steps
// depends on ffha_pkg
`default_nettype none

module ffha_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ffha_pkg::dp_status_t status_i,
  output ffha_pkg::cmd_t            cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_RD, S_EV, S_AHIT, S_POST, S_ICHK, S_IMOV,
    S_FMARK, S_FRD, S_FNXT, S_FPREV, S_DCHK, S_DMOV, S_BAD, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;
  logic   del_prev_q, del_prev_d;

  // next state and datapath command
  always_comb begin
    state_d    = state_q;
    del_prev_d = del_prev_q;
    cmd_o      = '{op: ffha_pkg::OP_NONE, st: ffha_pkg::ST_OK};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.op = ffha_pkg::OP_LOAD;
          state_d  = S_PRE;
        end
      end
      S_PRE: state_d = status_i.pre_err ? S_FIN : S_RD;
      S_RD: begin
        if (!status_i.scan_end) begin
          cmd_o.op = ffha_pkg::OP_READ;
          state_d  = S_EV;
        end else begin
          state_d  = S_FIN;
          cmd_o.op = ffha_pkg::OP_SETST;
          case (status_i.func)
            ffha_pkg::FUNC_ALLOC: begin
              if (!status_i.aln || !status_i.best_vld) begin
                cmd_o.st = ffha_pkg::ST_NOFIT;
              end else if (status_i.full) begin
                cmd_o.st = ffha_pkg::ST_FULL;
              end else begin
                cmd_o.op = ffha_pkg::OP_PAD;
                state_d  = S_POST;
              end
            end
            ffha_pkg::FUNC_ADD: begin
              if (status_i.full) begin
                cmd_o.st = ffha_pkg::ST_FULL;
              end else begin
                cmd_o.op = ffha_pkg::OP_ADD_SET;
                state_d  = S_POST;
              end
            end
            default: cmd_o.st = ffha_pkg::ST_BAD;
          endcase
        end
      end
      S_EV: begin
        cmd_o.op = ffha_pkg::OP_EVAL;
        if (status_i.match) begin
          case (status_i.func)
            ffha_pkg::FUNC_ALLOC: state_d = S_AHIT;
            ffha_pkg::FUNC_FREE:  state_d = S_FMARK;
            default:              state_d = S_BAD;
          endcase
        end else begin
          state_d = S_RD;
        end
      end
      S_AHIT: begin
        cmd_o.op = ffha_pkg::OP_ALLOC_HIT;
        state_d  = S_POST;
      end
      // pending inserts
      S_POST: begin
        if (status_i.pend1) begin
          state_d = S_ICHK;
        end else if (status_i.pend2) begin
          cmd_o.op = ffha_pkg::OP_NEXT_INS;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ICHK: begin
        if (status_i.idx_eq_ins) begin
          cmd_o.op = ffha_pkg::OP_IWRITE;
          state_d  = S_POST;
        end else begin
          cmd_o.op = ffha_pkg::OP_IRD;
          state_d  = S_IMOV;
        end
      end
      S_IMOV: begin
        cmd_o.op = ffha_pkg::OP_IMOVE;
        state_d  = S_ICHK;
      end
      // free and merge
      S_FMARK: begin
        if (status_i.cur_free) begin
          cmd_o.op = ffha_pkg::OP_SETST;
          cmd_o.st = ffha_pkg::ST_BAD;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = ffha_pkg::OP_FMARK;
          state_d  = status_i.has_next ? S_FRD : S_FPREV;
        end
      end
      S_FRD: begin
        cmd_o.op = ffha_pkg::OP_READ;
        state_d  = S_FNXT;
      end
      S_FNXT: begin
        if (status_i.next_merge) begin
          cmd_o.op   = ffha_pkg::OP_FNEXT;
          del_prev_d = 1'b0;
          state_d    = S_DCHK;
        end else begin
          state_d = S_FPREV;
        end
      end
      S_FPREV: begin
        if (status_i.prev_merge) begin
          cmd_o.op   = ffha_pkg::OP_FPREV;
          del_prev_d = 1'b1;
          state_d    = S_DCHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DCHK: begin
        if (status_i.del_last) begin
          cmd_o.op = ffha_pkg::OP_DEND;
          state_d  = del_prev_q ? S_FIN : S_FPREV;
        end else begin
          cmd_o.op = ffha_pkg::OP_DRD;
          state_d  = S_DMOV;
        end
      end
      S_DMOV: begin
        cmd_o.op = ffha_pkg::OP_DMOVE;
        state_d  = S_DCHK;
      end
      S_BAD: begin
        cmd_o.op = ffha_pkg::OP_SETST;
        cmd_o.st = ffha_pkg::ST_BAD;
        state_d  = S_FIN;
      end
      S_FIN: begin
        cmd_o.op = ffha_pkg::OP_OUT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      busy_q     <= 1'b0;
      del_prev_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      del_prev_q <= del_prev_d;
      if (state_q == S_IDLE && start) busy_q <= 1'b1;
      else if (state_q == S_FIN) busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

endmodule

`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
// top level of the first fit heap allocator
// depends on ffha_pkg, ffha_ctrl and ffha_datapath
//
// channel   signals                 beat taken when
// request   start, busy, req_i      rising edge with start high and busy low
// result    done_o, res_o           rising edge that ends the done_o cycle
//
// one request at a time; busy stays high until its result beat is shown
// each table entry visited takes a memory read, then a compare;
// an insert or delete shifts the table tail with a read and a move per moved entry
// reset clears the entry count but not the table entries; no clearing pass over the table
// the result beat lasts one cycle and cannot be stalled
`default_nettype none

module first_fit_heap_allocator (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire ffha_pkg::req_t req_i,
  output logic                done_o,
  output ffha_pkg::res_t      res_o
);

  ffha_pkg::cmd_t       cmd;
  ffha_pkg::dp_status_t dp_status;

  // sequencer
  ffha_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (dp_status),
    .cmd_o    (cmd)
  );

  // table and compare logic
  ffha_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i),
    .status_o (dp_status),
    .done_o   (done_o),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire

>>> rtl/ffha_checker.sv
// port level checks for the first fit heap allocator, bound to the top
// depends on ffha_pkg and first_fit_heap_allocator_defines.svh
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire ffha_pkg::res_t res_o
);

  logic accept;
  assign accept = start && !busy;

  // an accepted beat keeps the block busy
  `FFHA_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy not raised after accept")
  // result beats are single cycle and never back to back
  `FFHA_ASSERT_NEXT(a_done_single, done_o, !done_o, "result beats back to back")
  // the block is free again when its result is shown
  `FFHA_ASSERT_NOW(a_idle_on_done, done_o, !busy, "busy while result shown")
  // failed requests report a null address
  `FFHA_ASSERT_NOW(a_fail_null, done_o && res_o.status != ffha_pkg::ST_OK,
                   res_o.data_addr == 32'd0, "nonzero address on failure")
  // payload addresses stay on the 16 byte grain
  `FFHA_ASSERT_NOW(a_addr_grain, done_o, res_o.data_addr[3:0] == 4'd0,
                   "address off grain")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

`default_nettype wire

>>> tb/tb_first_fit_heap_allocator.sv
// self-checking testbench for the first fit heap allocator
// depends on ffha_pkg and first_fit_heap_allocator
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  typedef bit [63:0] u64_t;

  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam int         Depth        = 64;
  localparam u64_t       AddrMask     = 64'hFFFF_FFFF;
  localparam int         CycleLimit   = 1500000;
  localparam int         MaxReports   = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  res_t res_o;

  // items waiting to go out and results still owed by the block
  req_t pending_reqs[$];
  res_t owed_results[$];
  int   sender_idle_pct = 0;
  int   mismatches = 0;
  int   cycles = 0;

  // own copy of the heap table
  u64_t heap_start[Depth];
  u64_t heap_pay[Depth];
  bit   heap_free[Depth];
  int   heap_cnt = 0;
  logic [31:0] live_addrs[$];

  first_fit_heap_allocator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void table_insert(int i, u64_t s, u64_t p, bit f);
    for (int j = heap_cnt; j > i; j--) begin
      heap_start[j] = heap_start[j-1];
      heap_pay[j]   = heap_pay[j-1];
      heap_free[j]  = heap_free[j-1];
    end
    heap_start[i] = s & AddrMask;
    heap_pay[i]   = p & AddrMask;
    heap_free[i]  = f;
    heap_cnt++;
  endfunction

  function automatic void table_delete(int i);
    for (int j = i; j < heap_cnt - 1; j++) begin
      heap_start[j] = heap_start[j+1];
      heap_pay[j]   = heap_pay[j+1];
      heap_free[j]  = heap_free[j+1];
    end
    heap_cnt--;
  endfunction

  // split off the tail only if it holds a header plus one grain
  function automatic void split_tail(int i, u64_t size);
    u64_t rest;
    rest = heap_pay[i] - size;
    if (heap_cnt >= Depth || rest < u64_t'(HeaderBytes + Grain)) return;
    table_insert(i + 1, heap_start[i] + HeaderBytes + size, rest - HeaderBytes, 1'b1);
    heap_pay[i] = size;
  endfunction

  function automatic logic [2:0] heap_alloc(u64_t size, u64_t al, output u64_t addr);
    u64_t am, best_pad, d, pad, p, ns, np;
    int   best;
    addr = 0;
    size = (size + GrainMask) & ~u64_t'(GrainMask);
    if (al != 0 && (al & (al - 1)) != 0) return ST_ALIGN;
    if (al <= Grain) begin
      for (int i = 0; i < heap_cnt; i++) begin
        if (heap_free[i] && heap_pay[i] >= size) begin
          heap_free[i] = 1'b0;
          split_tail(i, size);
          addr = (heap_start[i] + HeaderBytes) & AddrMask;
          return ST_OK;
        end
      end
      return ST_NOFIT;
    end
    am = al - 1;
    best_pad = 0;
    best = Depth;
    // first an already aligned free block
    for (int i = 0; i < heap_cnt; i++) begin
      d = (heap_start[i] + HeaderBytes) & AddrMask;
      if (heap_free[i] && (d & am) == 0 && heap_pay[i] >= size) begin
        heap_free[i] = 1'b0;
        split_tail(i, size);
        addr = d;
        return ST_OK;
      end
    end
    // then the smallest block that fits with a front pad
    for (int i = 0; i < heap_cnt; i++) begin
      if (!heap_free[i]) continue;
      p = heap_pay[i];
      d = (heap_start[i] + HeaderBytes) & AddrMask;
      pad = (64'd0 - d) & am;
      if (pad < Grain) pad += al;
      if (p >= pad && p - pad >= HeaderBytes && p - pad - HeaderBytes >= size &&
          (best == Depth || p < heap_pay[best])) begin
        best = i;
        best_pad = pad;
      end
    end
    if (best == Depth) return ST_NOFIT;
    if (heap_cnt >= Depth) return ST_FULL;
    ns = heap_start[best] + HeaderBytes + best_pad;
    np = heap_pay[best] - best_pad - HeaderBytes;
    heap_pay[best] = best_pad;
    table_insert(best + 1, ns, np, 1'b0);
    split_tail(best + 1, size);
    addr = (heap_start[best+1] + HeaderBytes) & AddrMask;
    return ST_OK;
  endfunction

  function automatic logic [2:0] heap_release(u64_t data);
    int i;
    for (i = 0; i < heap_cnt; i++)
      if (((heap_start[i] + HeaderBytes) & AddrMask) == data) break;
    if (i == heap_cnt || heap_free[i]) return ST_BAD;
    heap_free[i] = 1'b1;
    if (i + 1 < heap_cnt && heap_free[i+1] &&
        ((heap_start[i] + HeaderBytes + heap_pay[i]) & AddrMask) == heap_start[i+1]) begin
      heap_pay[i] = (heap_pay[i] + HeaderBytes + heap_pay[i+1]) & AddrMask;
      table_delete(i + 1);
    end
    if (i > 0 && heap_free[i-1] &&
        ((heap_start[i-1] + HeaderBytes + heap_pay[i-1]) & AddrMask) == heap_start[i]) begin
      heap_pay[i-1] = (heap_pay[i-1] + HeaderBytes + heap_pay[i]) & AddrMask;
      table_delete(i);
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] heap_add_region(u64_t base, u64_t len);
    u64_t last, bl;
    int   i;
    if (((base | len) & GrainMask) != 0) return ST_ALIGN;
    if (len < u64_t'(HeaderBytes + Grain) || len - 1 > AddrMask - base) return ST_BAD;
    last = base + len - 1;
    for (i = 0; i < heap_cnt; i++) begin
      bl = heap_start[i] + HeaderBytes + heap_pay[i] - 1;
      if (base <= bl && heap_start[i] <= last) return ST_BAD;
    end
    if (heap_cnt >= Depth) return ST_FULL;
    for (i = 0; i < heap_cnt; i++)
      if (heap_start[i] > base) break;
    table_insert(i, base, len - HeaderBytes, 1'b1);
    return ST_OK;
  endfunction

  // predict the result of one request, then queue request and result
  task automatic queue_request(logic [1:0] f, logic [31:0] sz, logic [31:0] al,
                               logic [31:0] ad);
    req_t r;
    res_t e;
    u64_t a;
    r = '{func: f, req_size: sz, req_align: al, req_addr: ad};
    a = 0;
    case (f)
      FUNC_ALLOC: e.status = heap_alloc(u64_t'(sz), u64_t'(al), a);
      FUNC_FREE:  e.status = heap_release(u64_t'(ad));
      FUNC_ADD:   e.status = heap_add_region(u64_t'(ad), u64_t'(sz));
      default:    e.status = ST_BAD;
    endcase
    if (e.status != ST_OK) a = 0;
    e.data_addr = a[31:0];
    if (f == FUNC_ALLOC && e.status == ST_OK) live_addrs.push_back(a[31:0]);
    if (f == FUNC_FREE && e.status == ST_OK) begin
      foreach (live_addrs[k]) begin
        if (live_addrs[k] == ad) begin
          live_addrs.delete(k);
          break;
        end
      end
    end
    pending_reqs.push_back(r);
    owed_results.push_back(e);
  endtask

  // one random request, mostly well formed
  task automatic queue_random;
    int          pick;
    logic [31:0] al;
    pick = $urandom_range(99);
    if (pick < 35) begin
      case ($urandom_range(5))
        0: al = 0;
        1: al = 32'd1 << $urandom_range(4);
        2, 3: al = 32'd1 << $urandom_range(5, 12);
        4: al = 32'd1 << $urandom_range(13, 31);
        default: al = $urandom;
      endcase
      queue_request(FUNC_ALLOC, $urandom_range(0, 400), al, $urandom);
    end else if (pick < 70 && live_addrs.size() > 0) begin
      queue_request(FUNC_FREE, $urandom, $urandom,
                    live_addrs[$urandom_range(live_addrs.size() - 1)]);
    end else if (pick < 82) begin
      queue_request(FUNC_ADD, $urandom_range(2, 160) * 16, $urandom,
                    $urandom_range(32'h1000, 32'h40000) * 16);
    end else if (pick < 88) begin
      queue_request(FUNC_FREE, $urandom, $urandom, $urandom);
    end else begin
      queue_request(2'($urandom_range(3)), $urandom, $urandom, $urandom);
    end
  endtask

  task automatic drain_all;
    while (pending_reqs.size() != 0 || owed_results.size() != 0) @(negedge clk_i);
  endtask

  // driver: one request beat per start/!busy edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) void'(pending_reqs.pop_front());
      if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        req_i <= pending_reqs[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each result beat with the oldest owed result
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result beat: addr %h status %0d",
                   res_o.data_addr, res_o.status);
      end else begin
        if (res_o.data_addr !== owed_results[0].data_addr ||
            res_o.status !== owed_results[0].status) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                     owed_results[0].data_addr, owed_results[0].status,
                     res_o.data_addr, res_o.status);
        end
        void'(owed_results.pop_front());
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed requests
    sender_idle_pct = 38;
    queue_request(FUNC_ALLOC, 32'd16, 32'd0, 32'd0);           // empty heap
    queue_request(FUNC_ADD, 32'h1000, 32'd0, 32'h0001_0000);
    queue_request(FUNC_ADD, 32'h100, 32'd0, 32'h0001_0008);    // misaligned base
    queue_request(FUNC_ADD, 32'h10, 32'd0, 32'h0002_0000);     // too short
    queue_request(FUNC_ADD, 32'h20, 32'd0, 32'hFFFF_FFF0);     // wraps
    queue_request(FUNC_ADD, 32'h100, 32'd0, 32'h0001_0800);    // overlaps
    queue_request(FUNC_ADD, 32'h10, 32'd0, 32'hFFFF_FFE0);     // too short at top
    queue_request(FUNC_ADD, 32'h20, 32'hFFFF_FFFF, 32'hFFFF_FFE0);
    queue_request(FUNC_ALLOC, 32'd0, 32'd0, 32'd0);            // size zero
    queue_request(FUNC_ALLOC, 32'd1, 32'd8, 32'd0);
    queue_request(FUNC_ALLOC, 32'd100, 32'd3, 32'd0);          // bad alignment
    queue_request(FUNC_ALLOC, 32'd40, 32'd64, 32'd0);          // front pad
    queue_request(FUNC_ALLOC, 32'd40, 32'd32, 32'd0);
    queue_request(FUNC_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0);    // nothing fits
    queue_request(FUNC_ALLOC, 32'd16, 32'h8000_0000, 32'd0);
    queue_request(FUNC_FREE, 32'd0, 32'd0, 32'h0001_0010);
    queue_request(FUNC_FREE, 32'd0, 32'd0, 32'h0001_0010);     // double free
    queue_request(FUNC_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(FUNC_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    while (live_addrs.size() != 0)
      queue_request(FUNC_FREE, 32'd0, 32'd0, live_addrs[live_addrs.size() - 1]);
    queue_request(FUNC_ALLOC, 32'hFF0, 32'd0, 32'd0);          // whole region
    drain_all();

    // random phases: sender idles often, then more, then never
    repeat (430) queue_random();
    drain_all();
    sender_idle_pct = 68;
    repeat (430) queue_random();
    drain_all();
    sender_idle_pct = 0;
    repeat (440) queue_random();
    drain_all();
    repeat (300) @(negedge clk_i);

    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> first_fit_heap_allocator.f
+incdir+rtl
rtl/ffha_pkg.sv
rtl/ffha_datapath.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
tb/tb_first_fit_heap_allocator.sv
